@@ rtl/alp_pkg.sv @@
// ----------------------------------------------------------------------------
// alp_pkg
// Shared types and constants for the aligned page locator: table sizes,
// field widths, result codes, register indexes and controller commands.
// ----------------------------------------------------------------------------
package alp_pkg;

  localparam int MAX_ALIGN_POINTS = 8;
  localparam int IDX_W            = $clog2(MAX_ALIGN_POINTS);
  localparam int CNT_W            = $clog2(MAX_ALIGN_POINTS + 1);
  localparam int ADDR_W           = 48;
  localparam int OFF_W            = 16;
  localparam int SHIFT_W          = 5;
  localparam int PSIZE_W          = OFF_W + 1;
  localparam int SECTOR_BITS      = 9;
  localparam int IN_TDATA_W       = 48;
  localparam int OUT_TDATA_W      = 72;

  localparam logic [SHIFT_W-1:0] SHIFT_MIN   = SHIFT_W'(9);
  localparam logic [SHIFT_W-1:0] SHIFT_MAX   = SHIFT_W'(16);
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(12);

  // Input item kind
  typedef enum logic {
    MODE_ADD    = 1'b0,
    MODE_LOCATE = 1'b1
  } mode_t;

  // Result status codes
  typedef enum logic [1:0] {
    RES_OK      = 2'd0,
    RES_PRESENT = 2'd1,
    RES_FULL    = 2'd2,
    RES_RANGE   = 2'd3
  } res_status_t;

  // Configuration register indexes
  typedef enum logic {
    CFG_PAGE_SHIFT   = 1'b0,
    CFG_BACKING_SIZE = 1'b1
  } cfg_idx_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_FIN1,
    S_FIN2,
    S_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic cap;   // capture the accepted item, restart the walk
    logic step;  // compare one table entry and advance
    logic fin1;  // add decision, or page base and offset
    logic fin2;  // range check for a locate
    logic load;  // move the result into the output register
  } alp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic count_zero;
    logic walk_last;
    logic is_add;
    logic out_free;
  } alp_stat_t;

endpackage

@@ rtl/alp_ctrl.sv @@
// ----------------------------------------------------------------------------
// alp_ctrl
// Sequencer for the locator: accepts one item, walks the alignment table
// one entry a cycle, runs the finishing steps and hands off the result.
// ----------------------------------------------------------------------------
module alp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  alp_pkg::alp_stat_t stat,
  output logic               in_ready,
  output alp_pkg::alp_cmd_t  cmd
);

  alp_pkg::state_t state_r;
  alp_pkg::state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= alp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      alp_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = stat.count_zero ? alp_pkg::S_FIN1 : alp_pkg::S_WALK;
        end
      end
      alp_pkg::S_WALK: begin
        if (stat.walk_last) begin
          state_nxt = alp_pkg::S_FIN1;
        end
      end
      alp_pkg::S_FIN1: begin
        state_nxt = stat.is_add ? alp_pkg::S_DONE : alp_pkg::S_FIN2;
      end
      alp_pkg::S_FIN2: begin
        state_nxt = alp_pkg::S_DONE;
      end
      alp_pkg::S_DONE: begin
        if (stat.out_free) begin
          state_nxt = alp_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = alp_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      alp_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.cap  = in_fire;
      end
      alp_pkg::S_WALK: begin
        cmd.step = 1'b1;
      end
      alp_pkg::S_FIN1: begin
        cmd.fin1 = 1'b1;
      end
      alp_pkg::S_FIN2: begin
        cmd.fin2 = 1'b1;
      end
      alp_pkg::S_DONE: begin
        cmd.load = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/alp_dp.sv @@
// ----------------------------------------------------------------------------
// alp_dp
// Datapath: configuration registers, alignment table, one shared compare
// unit for the walk, page arithmetic and the output register.
// ----------------------------------------------------------------------------
module alp_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  alp_pkg::alp_cmd_t                cmd,
  output alp_pkg::alp_stat_t               stat,
  input  logic                             in_mode,
  input  logic [alp_pkg::ADDR_W-1:0]       in_location,
  input  logic                             cfg_fire,
  input  logic                             cfg_idx,
  input  logic [alp_pkg::ADDR_W-1:0]       cfg_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [alp_pkg::OUT_TDATA_W-1:0]  out_data
);

  // Configuration
  logic [alp_pkg::SHIFT_W-1:0] page_shift_r;
  logic [alp_pkg::ADDR_W-1:0]  backing_size_r;

  // Table and walk state
  logic [alp_pkg::ADDR_W-1:0]  table_r [alp_pkg::MAX_ALIGN_POINTS];
  logic [alp_pkg::CNT_W-1:0]   count_r;
  logic [alp_pkg::IDX_W-1:0]   idx_r;
  logic                        found_r;
  logic [alp_pkg::ADDR_W-1:0]  best_r;
  logic                        mode_r;
  logic [alp_pkg::ADDR_W-1:0]  loc_r;

  // Page results
  logic [alp_pkg::ADDR_W-1:0]  base_r;
  logic [alp_pkg::OFF_W-1:0]   offset_r;
  alp_pkg::res_status_t        res_status_r;

  // Output register
  logic                        out_valid_r;
  alp_pkg::res_status_t        o_status_r;
  logic                        o_mis_r;
  logic [alp_pkg::ADDR_W-1:0]  o_base_r;
  logic [alp_pkg::OFF_W-1:0]   o_offset_r;

  logic [alp_pkg::ADDR_W-1:0]  entry;
  logic [alp_pkg::SHIFT_W-1:0] eff_shift;
  logic [alp_pkg::PSIZE_W-1:0] psize;
  logic [alp_pkg::OFF_W-1:0]   pmask;
  logic [alp_pkg::OFF_W-1:0]   best_phase;
  logic [alp_pkg::OFF_W-1:0]   offset_nxt;
  logic [alp_pkg::ADDR_W-1:0]  headroom;
  logic                        bad;
  logic                        mis;

  assign entry = table_r[idx_r];

  // Clamp page shift and derive page size and mask
  always_comb begin
    if (page_shift_r < alp_pkg::SHIFT_MIN) begin
      eff_shift = alp_pkg::SHIFT_MIN;
    end else if (page_shift_r > alp_pkg::SHIFT_MAX) begin
      eff_shift = alp_pkg::SHIFT_MAX;
    end else begin
      eff_shift = page_shift_r;
    end
    psize      = alp_pkg::PSIZE_W'(1) << eff_shift;
    pmask      = alp_pkg::OFF_W'(psize - alp_pkg::PSIZE_W'(1));
    best_phase = best_r[alp_pkg::OFF_W-1:0] & pmask;
    offset_nxt = (loc_r[alp_pkg::OFF_W-1:0] - best_phase) & pmask;
    headroom   = backing_size_r - base_r;
    bad        = (loc_r >= backing_size_r) ||
                 (headroom < alp_pkg::ADDR_W'(psize));
    mis        = (loc_r[alp_pkg::SECTOR_BITS-1:0] != '0);
  end

  // Status to the controller
  always_comb begin
    stat.count_zero = (count_r == '0);
    stat.walk_last  = ({1'b0, idx_r} == count_r - alp_pkg::CNT_W'(1));
    stat.is_add     = (mode_r == alp_pkg::MODE_ADD);
    stat.out_free   = !out_valid_r || out_ready;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_shift_r   <= alp_pkg::SHIFT_RESET;
      backing_size_r <= '0;
    end else if (cfg_fire) begin
      case (cfg_idx)
        alp_pkg::CFG_PAGE_SHIFT:   page_shift_r   <= cfg_value[alp_pkg::SHIFT_W-1:0];
        alp_pkg::CFG_BACKING_SIZE: backing_size_r <= cfg_value;
        default:                   page_shift_r   <= page_shift_r;
      endcase
    end
  end

  // Table fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.fin1 && (mode_r == alp_pkg::MODE_ADD) && !found_r &&
                 (count_r != alp_pkg::CNT_W'(alp_pkg::MAX_ALIGN_POINTS))) begin
      count_r <= count_r + alp_pkg::CNT_W'(1);
    end
  end

  // Store a new alignment point
  always_ff @(posedge clk) begin
    if (cmd.fin1 && (mode_r == alp_pkg::MODE_ADD) && !found_r &&
        (count_r != alp_pkg::CNT_W'(alp_pkg::MAX_ALIGN_POINTS))) begin
      table_r[count_r[alp_pkg::IDX_W-1:0]] <= loc_r;
    end
  end

  // Capture the item and walk the table
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      mode_r  <= in_mode;
      loc_r   <= in_location;
      idx_r   <= '0;
      found_r <= 1'b0;
      best_r  <= '0;
    end else if (cmd.step) begin
      idx_r <= idx_r + alp_pkg::IDX_W'(1);
      if (entry == loc_r) begin
        found_r <= 1'b1;
      end
      if ((entry <= loc_r) && (entry > best_r)) begin
        best_r <= entry;
      end
    end
  end

  // Finishing steps: add decision or page base, then range check
  always_ff @(posedge clk) begin
    if (cmd.fin1) begin
      offset_r <= offset_nxt;
      base_r   <= loc_r - alp_pkg::ADDR_W'(offset_nxt);
      if (found_r) begin
        res_status_r <= alp_pkg::RES_PRESENT;
      end else if (count_r == alp_pkg::CNT_W'(alp_pkg::MAX_ALIGN_POINTS)) begin
        res_status_r <= alp_pkg::RES_FULL;
      end else begin
        res_status_r <= alp_pkg::RES_OK;
      end
    end else if (cmd.fin2) begin
      res_status_r <= bad ? alp_pkg::RES_RANGE : alp_pkg::RES_OK;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload; add results carry zero page fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      o_status_r <= res_status_r;
      if (mode_r == alp_pkg::MODE_ADD) begin
        o_mis_r    <= 1'b0;
        o_base_r   <= '0;
        o_offset_r <= '0;
      end else begin
        o_mis_r    <= mis;
        o_base_r   <= base_r;
        o_offset_r <= offset_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = {5'b0, o_offset_r, o_base_r, o_mis_r, o_status_r};

endmodule

@@ rtl/aligned_page_locator.sv @@
// ----------------------------------------------------------------------------
// aligned_page_locator
// Alignment point table with page locator: adds points, finds the page
// base and offset of a location and checks it against the backing store.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one item per transfer. in_tuser is the mode (0 add point,
//            1 locate), in_tdata the 48-bit location.
//   out_*  : one result per input item: status, misaligned flag, page base
//            and page offset, in that order from bit 0 of out_tdata.
//   cfg_*  : register writes, index 0 page_shift, index 1 backing_size;
//            write only while the block is idle. cfg_ready is always high.
// Timing: one item at a time. After acceptance the table is walked one
//   entry per cycle through a single comparator, over all the stored
//   points (0 to 8); then the finishing steps run (FIN1, plus FIN2
//   for a locate) and the result is loaded. The next item is taken in the
//   cycle after the result is loaded.
// Reset: the table is emptied, page_shift returns to 12, backing_size to 0,
//   and no result is pending.
// Stalls: a result waits in the output register while out_tready is low;
//   the block still takes the next item, and holds its following result
//   back until the register frees.
// ----------------------------------------------------------------------------
module aligned_page_locator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [alp_pkg::IN_TDATA_W-1:0]  in_tdata,   // [47:0] location
  input  logic                            in_tuser,   // [0] mode
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [1:0] status, [2] misaligned, [50:3] page_base, [66:51] page_offset,
  // [71:67] zero
  output logic [alp_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [alp_pkg::ADDR_W-1:0]      cfg_data
);

  alp_pkg::alp_cmd_t  cmd;
  alp_pkg::alp_stat_t stat;
  logic               in_ready;
  logic               in_fire;
  logic               cfg_fire;

  assign in_tready = in_ready;
  assign in_fire   = in_tvalid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;

  // Sequencer
  alp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // Table, arithmetic and output register
  alp_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_mode     (in_tuser),
    .in_location (in_tdata),
    .cfg_fire    (cfg_fire),
    .cfg_idx     (cfg_index),
    .cfg_value   (cfg_data),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_data    (out_tdata)
  );

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the aligned page locator. A short directed table fills the
// alignment point table, runs it into the full and duplicate cases and
// locates pages at the address and shift extremes. Random adds and locates
// follow under several register settings and handshake idling patterns,
// one of them with a long output stall. Every result is compared with a
// local prediction of the table and page arithmetic, or a typed result.
// ----------------------------------------------------------------------------
module testbench;
  import alp_pkg::*;

  localparam int          SETTLE_CYCLES = 16;      // longest walk plus margin
  localparam int          CYCLE_LIMIT   = 300000;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          SUB_ITEMS     = 58;
  localparam logic [47:0] ADDR_MASK     = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    res_status_t       status;
    logic              misaligned;
    logic [ADDR_W-1:0] page_base;
    logic [OFF_W-1:0]  page_offset;
  } page_result_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    mode_t             mode;
    cfg_idx_t          reg_idx;
    logic [ADDR_W-1:0] value;
    logic              typed;
    page_result_t      res;
  } dir_row_t;

  localparam page_result_t NO_RESULT = '{RES_OK, 1'b0, 48'h0, 16'h0};
  localparam page_result_t ADD_OK    = '{RES_OK, 1'b0, 48'h0, 16'h0};
  localparam page_result_t ADD_DUP   = '{RES_PRESENT, 1'b0, 48'h0, 16'h0};
  localparam page_result_t ADD_FULL  = '{RES_FULL, 1'b0, 48'h0, 16'h0};

  // Directed stimulus: typed results only where they are plain to see
  localparam dir_row_t DIRECTED_ROWS [26] = '{
    '{ROW_ITEM, MODE_LOCATE, CFG_PAGE_SHIFT, 48'h0, 1'b1,
      '{RES_RANGE, 1'b0, 48'h0, 16'h0}},
    '{ROW_ITEM, MODE_LOCATE, CFG_PAGE_SHIFT, 48'hFFFF_FFFF_FFFF, 1'b1,
      '{RES_RANGE, 1'b1, 48'hFFFF_FFFF_F000, 16'h0FFF}},
    '{ROW_ITEM, MODE_ADD, CFG_PAGE_SHIFT, 48'h0, 1'b1, ADD_OK},
    '{ROW_ITEM, MODE_ADD, CFG_PAGE_SHIFT, 48'h0, 1'b1, ADD_DUP},
    '{ROW_ITEM, MODE_ADD, CFG_PAGE_SHIFT, 48'hFFFF_FFFF_FFFF, 1'b1, ADD_OK},
    '{ROW_ITEM, MODE_ADD, CFG_PAGE_SHIFT, 48'h1000, 1'b1, ADD_OK},
    '{ROW_ITEM, MODE_ADD, CFG_PAGE_SHIFT, 48'h200, 1'b1, ADD_OK},
    '{ROW_ITEM, MODE_ADD, CFG_PAGE_SHIFT, 48'h1_0000_0200, 1'b1, ADD_OK},
    '{ROW_ITEM, MODE_ADD, CFG_PAGE_SHIFT, 48'h7FF, 1'b1, ADD_OK},
    '{ROW_ITEM, MODE_ADD, CFG_PAGE_SHIFT, 48'h8000_0000_0001, 1'b1, ADD_OK},
    '{ROW_ITEM, MODE_ADD, CFG_PAGE_SHIFT, 48'h123_4567, 1'b1, ADD_OK},
    '{ROW_ITEM, MODE_ADD, CFG_PAGE_SHIFT, 48'h2000, 1'b1, ADD_FULL},
    '{ROW_ITEM, MODE_ADD, CFG_PAGE_SHIFT, 48'h1000, 1'b1, ADD_DUP},
    '{ROW_CFG, MODE_ADD, CFG_BACKING_SIZE, 48'hFFFF_FFFF_FFFF, 1'b0, NO_RESULT},
    '{ROW_CFG, MODE_ADD, CFG_PAGE_SHIFT, 48'h0, 1'b0, NO_RESULT},
    '{ROW_ITEM, MODE_LOCATE, CFG_PAGE_SHIFT, 48'h1_0000_0345, 1'b0, NO_RESULT},
    '{ROW_ITEM, MODE_LOCATE, CFG_PAGE_SHIFT, 48'h800, 1'b0, NO_RESULT},
    '{ROW_CFG, MODE_ADD, CFG_PAGE_SHIFT, 48'h1F, 1'b0, NO_RESULT},
    '{ROW_ITEM, MODE_LOCATE, CFG_PAGE_SHIFT, 48'h8000_0000_1234, 1'b0, NO_RESULT},
    '{ROW_ITEM, MODE_LOCATE, CFG_PAGE_SHIFT, 48'hFFFF_FFFF_FFFF, 1'b0, NO_RESULT},
    '{ROW_CFG, MODE_ADD, CFG_BACKING_SIZE, 48'h10_0000, 1'b0, NO_RESULT},
    '{ROW_ITEM, MODE_LOCATE, CFG_PAGE_SHIFT, 48'hF_FE00, 1'b0, NO_RESULT},
    '{ROW_ITEM, MODE_LOCATE, CFG_PAGE_SHIFT, 48'h10_0000, 1'b0, NO_RESULT},
    '{ROW_CFG, MODE_ADD, CFG_BACKING_SIZE, 48'h0, 1'b0, NO_RESULT},
    '{ROW_ITEM, MODE_LOCATE, CFG_PAGE_SHIFT, 48'h1234, 1'b0, NO_RESULT},
    '{ROW_CFG, MODE_ADD, CFG_PAGE_SHIFT, 48'hC, 1'b0, NO_RESULT}
  };

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_index  = 1'b0;
  logic [ADDR_W-1:0]      cfg_data   = '0;

  // Local copy of the block's state and registers
  logic [ADDR_W-1:0]  point_table [MAX_ALIGN_POINTS];
  int                 point_count  = 0;
  logic [SHIFT_W-1:0] cur_shift    = SHIFT_RESET;
  logic [ADDR_W-1:0]  cur_backing  = '0;

  page_result_t pending_results [$];
  int           mismatch_count = 0;
  int           cycle_count    = 0;
  int           tx_idle_pct    = 0;
  int           rx_idle_pct    = 0;
  int           hold_asked     = 0;
  int           hold_seen      = 0;
  int           stall_left     = 0;

  aligned_page_locator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  // Work out the result of one item and advance the table
  function automatic page_result_t apply_to_table(mode_t mode, logic [ADDR_W-1:0] loc);
    page_result_t      r;
    logic              found;
    logic [SHIFT_W-1:0] sh;
    logic [ADDR_W-1:0] pmask;
    logic [ADDR_W-1:0] best;
    logic [ADDR_W-1:0] offs;
    logic [ADDR_W-1:0] base;
    r = NO_RESULT;
    if (mode == MODE_ADD) begin
      found = 1'b0;
      for (int i = 0; i < point_count; i++)
        if (point_table[i] == loc) found = 1'b1;
      if (found) begin
        r.status = RES_PRESENT;
      end else if (point_count >= MAX_ALIGN_POINTS) begin
        r.status = RES_FULL;
      end else begin
        point_table[point_count] = loc;
        point_count++;
      end
    end else begin
      sh = cur_shift;
      if (sh < SHIFT_MIN) sh = SHIFT_MIN;
      if (sh > SHIFT_MAX) sh = SHIFT_MAX;
      pmask = (ADDR_W'(1) << sh) - ADDR_W'(1);
      best  = '0;
      for (int i = 0; i < point_count; i++)
        if (point_table[i] <= loc && point_table[i] > best) best = point_table[i];
      best  = best & pmask;
      offs  = (loc - best) & pmask;
      base  = loc - offs;
      r.page_base   = base;
      r.page_offset = offs[OFF_W-1:0];
      r.misaligned  = |loc[SECTOR_BITS-1:0];
      if (loc >= cur_backing || base >= cur_backing || (cur_backing - base) < pmask + 1)
        r.status = RES_RANGE;
    end
    return r;
  endfunction

  // Offer one item, idling first at random; hold tvalid high after the transfer
  task automatic offer_item(mode_t mode, logic [ADDR_W-1:0] loc, logic typed,
                            page_result_t typed_res);
    page_result_t r;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= loc;
    in_tuser  <= mode;
    do @(posedge clk); while (!in_tready);
    r = apply_to_table(mode, loc);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  // Write a register once the block has drained
  task automatic write_register(cfg_idx_t idx, logic [ADDR_W-1:0] data);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_PAGE_SHIFT) cur_shift = data[SHIFT_W-1:0];
    else cur_backing = data;
  endtask

  task automatic random_item();
    logic [ADDR_W-1:0] loc;
    logic [ADDR_W-1:0] pick;
    pick = point_table[$urandom_range(point_count - 1)];
    if ($urandom_range(99) < 30) begin
      // mostly points already stored, some new ones
      loc = ($urandom_range(99) < 70) ? pick : rand_addr();
      offer_item(MODE_ADD, loc, 1'b0, NO_RESULT);
    end else begin
      case ($urandom_range(9))
        0, 1:    loc = pick + ADDR_W'($urandom_range(0, 'h3_FFFF));
        2:       loc = pick - ADDR_W'($urandom_range(0, 'h3FF));
        3:       loc = pick;
        4, 5:    loc = (cur_backing != 0) ? rand_addr() % cur_backing : rand_addr();
        6:       loc = rand_addr() & ~ADDR_W'(511);
        7:       loc = cur_backing - ADDR_W'($urandom_range(0, 'h2_0000));
        default: loc = rand_addr();
      endcase
      offer_item(MODE_LOCATE, loc, 1'b0, NO_RESULT);
    end
  endtask

  // Output side: random idling, plus one long hold when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (hold_seen != hold_asked) begin
      hold_seen  <= hold_asked;
      stall_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    page_result_t want;
    page_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{res_status_t'(out_tdata[1:0]), out_tdata[2], out_tdata[50:3],
              out_tdata[66:51]};
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: %h", $time, got);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          mismatch_count++;
        end
        if (got.misaligned !== want.misaligned) begin
          $display("%0t: misaligned expected %0b actual %0b", $time, want.misaligned,
                   got.misaligned);
          mismatch_count++;
        end
        if (got.page_base !== want.page_base) begin
          $display("%0t: page_base expected %h actual %h", $time, want.page_base,
                   got.page_base);
          mismatch_count++;
        end
        if (got.page_offset !== want.page_offset) begin
          $display("%0t: page_offset expected %h actual %h", $time, want.page_offset,
                   got.page_offset);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < MAX_ALIGN_POINTS; i++) point_table[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part
    for (int r = 0; r < $size(DIRECTED_ROWS); r++) begin
      if (DIRECTED_ROWS[r].kind == ROW_CFG)
        write_register(DIRECTED_ROWS[r].reg_idx, DIRECTED_ROWS[r].value);
      else
        offer_item(DIRECTED_ROWS[r].mode, DIRECTED_ROWS[r].value,
                   DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].res);
    end

    // Random part: three idling patterns, fresh registers for each slice
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 69 : 0;
      rx_idle_pct = (ph == 0) ? 69 : (ph == 1) ? 27 : 0;
      for (int sp = 0; sp < 4; sp++) begin
        case ($urandom_range(7))
          0:       write_register(CFG_PAGE_SHIFT, ADDR_W'({rand_addr() >> SHIFT_W, 5'd0}));
          1:       write_register(CFG_PAGE_SHIFT, 48'd9);
          2:       write_register(CFG_PAGE_SHIFT, 48'd16);
          3:       write_register(CFG_PAGE_SHIFT, 48'd31);
          default: write_register(CFG_PAGE_SHIFT,
                                  ADDR_W'({rand_addr() >> SHIFT_W, 5'($urandom_range(31))}));
        endcase
        case ($urandom_range(9))
          0:       write_register(CFG_BACKING_SIZE, 48'h0);
          1, 2:    write_register(CFG_BACKING_SIZE, ADDR_MASK);
          3:       write_register(CFG_BACKING_SIZE, ADDR_W'($urandom_range(1, 'h10_0000)));
          default: write_register(CFG_BACKING_SIZE, rand_addr());
        endcase
        // long output stall while items keep coming
        if (ph == 2 && sp == 0) hold_asked = hold_asked + 1;
        repeat (SUB_ITEMS) random_item();
      end
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
